### hw/rtl/scp_pkg.sv
// shared types and constants for the second-chance page replacer
`timescale 1ns / 1ps

package scp_pkg;

    localparam int NUM_FRAMES_DEF = 16;
    localparam int PAGE_BITS_DEF  = 16;
    localparam int CFG_W          = 5;
    localparam int CNT_W          = 32;

    localparam logic [CFG_W-1:0] FIU_RESET = 5'd16;

    // commands broadcast to every cell
    typedef struct packed {
        logic clear_all;
        logic hit_set;
        logic fill_wr;
        logic sweep_step;
        logic evict;
    } t_cell_cmd;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SEARCH = 4'b0010,
        S_SWEEP  = 4'b0100,
        S_EMIT   = 4'b1000
    } t_state;

endpackage

### hw/rtl/scp_cell.sv
// one page frame of the replacer chain: tag, reference bit and hand token
`timescale 1ns / 1ps

module scp_cell import scp_pkg::*; #(
    parameter int IDX        = 0,
    parameter int NUM_FRAMES = NUM_FRAMES_DEF,
    parameter int PAGE_BITS  = PAGE_BITS_DEF,
    parameter int CAP_W      = $clog2(NUM_FRAMES + 1),
    parameter int IDX_W      = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cell_cmd            i_cmd,
    input  logic [PAGE_BITS-1:0] i_page,
    input  logic [CAP_W-1:0]     i_fill,
    input  logic [IDX_W-1:0]     i_last,
    input  logic                 i_tok_prev,
    output logic                 o_tok_next,
    output logic                 o_tok_wrap,
    output logic                 o_tok,
    output logic                 o_ref,
    output logic [PAGE_BITS-1:0] o_tag,
    output logic                 o_match
);

    localparam logic [CAP_W-1:0] MY_POS = CAP_W'(IDX);
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic [PAGE_BITS-1:0] r_tag, n_tag;
    logic                 r_ref, n_ref;
    logic                 r_tok, n_tok;
    logic                 w_is_last, w_fill_here;

    assign w_is_last   = (MY_IDX == i_last);
    assign w_fill_here = i_cmd.fill_wr && (MY_POS == i_fill);

    always_comb begin
        n_tag = r_tag;
        n_ref = r_ref;
        n_tok = r_tok;
        if (i_cmd.clear_all) begin
            n_ref = 1'b0;
            n_tok = (IDX == 0);
        end else begin
            if (i_cmd.hit_set && o_match) begin
                n_ref = 1'b1;
            end
            if (w_fill_here) begin
                n_tag = i_page;
                n_ref = 1'b0;
            end
            if (i_cmd.sweep_step) begin
                // token cell loses its second chance or gets the new page
                if (r_tok) begin
                    n_ref = 1'b0;
                    if (i_cmd.evict) begin
                        n_tag = i_page;
                    end
                end
                n_tok = i_tok_prev;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref <= 1'b0;
            r_tok <= (IDX == 0);
        end else begin
            r_ref <= n_ref;
            r_tok <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag <= n_tag;
    end

    assign o_match    = (MY_POS < i_fill) && (r_tag == i_page);
    assign o_tok_next = r_tok && !w_is_last;
    assign o_tok_wrap = r_tok && w_is_last;
    assign o_tok      = r_tok;
    assign o_ref      = r_ref;
    assign o_tag      = r_tag;

endmodule

### hw/rtl/second_chance_page_replacer_unit.sv
// top level of the second-chance (clock) page replacer
// a hit or a fill of a free frame goes from S_SEARCH through S_EMIT into the result register
// a miss on a full set sweeps in S_SWEEP first, clearing reference bits until an unreferenced
//   frame is evicted; the token moves one cell per cycle along the chain
// throughput: one request in flight; the next is taken while a result waits in the output
// reset (synchronous, active low): frames empty, hand at frame 0, counters zero, capacity 16
`timescale 1ns / 1ps

module second_chance_page_replacer_unit import scp_pkg::*; #(
    parameter int NUM_FRAMES = NUM_FRAMES_DEF,
    parameter int PAGE_BITS  = PAGE_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request channel
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [PAGE_BITS-1:0] i_page,
    // result channel
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_hit,
    output logic                 o_evicted_valid,
    output logic [PAGE_BITS-1:0] o_evicted_page,
    output logic [CNT_W-1:0]     o_hit_total,
    output logic [CNT_W-1:0]     o_miss_total,
    // configuration: frames_in_use
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int CAP_W = $clog2(NUM_FRAMES + 1);
    localparam int IDX_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int CW    = (CAP_W > CFG_W) ? CAP_W : CFG_W;

    localparam logic [CW-1:0]    MAXF    = CW'(NUM_FRAMES);
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // control state
    t_state               r_state, n_state;
    logic [CFG_W-1:0]     r_fiu;
    logic [CAP_W-1:0]     r_fill;
    logic [CNT_W-1:0]     r_hit_cnt, r_miss_cnt;
    logic                 r_out_valid;

    // request and pending result
    logic [PAGE_BITS-1:0] r_page;
    logic                 r_res_hit, r_res_ev;
    logic [PAGE_BITS-1:0] r_res_evp;

    // output payload
    logic                 r_o_hit, r_o_ev;
    logic [PAGE_BITS-1:0] r_o_evp;
    logic [CNT_W-1:0]     r_o_hit_tot, r_o_miss_tot;

    // effective capacity: zero acts as one, clipped at the built frame count
    logic [CW-1:0]        w_fiu_ext, w_cap_wide;
    logic [CAP_W-1:0]     w_cap;
    logic [IDX_W-1:0]     w_last;

    assign w_fiu_ext  = CW'(r_fiu);
    assign w_cap_wide = (w_fiu_ext == '0) ? CW'(1) :
                        ((w_fiu_ext > MAXF) ? MAXF : w_fiu_ext);
    assign w_cap      = CAP_W'(w_cap_wide);
    assign w_last     = IDX_W'(w_cap_wide - CW'(1));

    // handshakes
    logic w_in_acc, w_cfg_acc, w_out_take, w_out_free;

    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign w_in_acc    = i_valid && !o_stall;
    assign w_cfg_acc   = i_cfg_valid && o_cfg_ready;
    assign w_out_take  = r_out_valid && !i_stall;
    assign w_out_free  = !r_out_valid || w_out_take;

    // cell chain
    t_cell_cmd            w_cmd;
    logic [NUM_FRAMES-1:0] w_tok, w_ref, w_match, w_tok_next, w_tok_wrap;
    logic [PAGE_BITS-1:0] w_tag [NUM_FRAMES];
    logic                 w_wrap_any;

    assign w_wrap_any = |w_tok_wrap;

    for (genvar g = 0; g < NUM_FRAMES; g++) begin : g_cell
        logic w_prev;
        if (g == 0) begin : g_head
            assign w_prev = w_wrap_any;
        end else begin : g_body
            assign w_prev = w_tok_next[g-1];
        end
        scp_cell #(
            .IDX        (g),
            .NUM_FRAMES (NUM_FRAMES),
            .PAGE_BITS  (PAGE_BITS),
            .CAP_W      (CAP_W),
            .IDX_W      (IDX_W)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cmd      (w_cmd),
            .i_page     (r_page),
            .i_fill     (r_fill),
            .i_last     (w_last),
            .i_tok_prev (w_prev),
            .o_tok_next (w_tok_next[g]),
            .o_tok_wrap (w_tok_wrap[g]),
            .o_tok      (w_tok[g]),
            .o_ref      (w_ref[g]),
            .o_tag      (w_tag[g]),
            .o_match    (w_match[g])
        );
    end

    // what sits under the clock hand
    logic                 w_hit, w_tok_ref;
    logic [PAGE_BITS-1:0] w_tok_tag;

    assign w_hit     = |w_match;
    assign w_tok_ref = |(w_tok & w_ref);

    always_comb begin
        w_tok_tag = '0;
        for (int k = 0; k < NUM_FRAMES; k++) begin
            w_tok_tag = w_tok_tag | (w_tag[k] & {PAGE_BITS{w_tok[k]}});
        end
    end

    // sequencer
    always_comb begin
        n_state          = r_state;
        w_cmd            = '0;
        w_cmd.clear_all  = w_cfg_acc;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (w_hit) begin
                    w_cmd.hit_set = 1'b1;
                    n_state       = S_EMIT;
                end else if (r_fill < w_cap) begin
                    w_cmd.fill_wr = 1'b1;
                    n_state       = S_EMIT;
                end else begin
                    n_state = S_SWEEP;
                end
            end
            S_SWEEP: begin
                w_cmd.sweep_step = 1'b1;
                w_cmd.evict      = !w_tok_ref;
                if (!w_tok_ref) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fiu       <= FIU_RESET;
            r_fill      <= '0;
            r_hit_cnt   <= '0;
            r_miss_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_cfg_acc) begin
                r_fiu  <= i_cfg_data;
                r_fill <= '0;
            end
            if (r_state == S_SEARCH) begin
                if (w_hit) begin
                    if (r_hit_cnt != CNT_MAX) begin
                        r_hit_cnt <= r_hit_cnt + CNT_W'(1);
                    end
                end else begin
                    if (r_miss_cnt != CNT_MAX) begin
                        r_miss_cnt <= r_miss_cnt + CNT_W'(1);
                    end
                    if (r_fill < w_cap) begin
                        r_fill <= r_fill + CAP_W'(1);
                    end
                end
            end
            if ((r_state == S_EMIT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (w_out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_page <= i_page;
        end
        if (r_state == S_SEARCH) begin
            r_res_hit <= w_hit;
            r_res_ev  <= 1'b0;
            r_res_evp <= '0;
        end
        if ((r_state == S_SWEEP) && !w_tok_ref) begin
            r_res_ev  <= 1'b1;
            r_res_evp <= w_tok_tag;
        end
        if ((r_state == S_EMIT) && w_out_free) begin
            r_o_hit      <= r_res_hit;
            r_o_ev       <= r_res_ev;
            r_o_evp      <= r_res_evp;
            r_o_hit_tot  <= r_hit_cnt;
            r_o_miss_tot <= r_miss_cnt;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_hit           = r_o_hit;
    assign o_evicted_valid = r_o_ev;
    assign o_evicted_page  = r_o_evp;
    assign o_hit_total     = r_o_hit_tot;
    assign o_miss_total    = r_o_miss_tot;

    // exactly one cell holds the clock hand
    a_tok_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(w_tok))
        else $error("clock hand token not one-hot");

    // never more filled frames than the capacity allows
    a_fill_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= w_cap)
        else $error("fill count beyond capacity");

    // a sweep only runs on a full frame set
    a_sweep_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP) |-> (r_fill == w_cap))
        else $error("sweep with free frames left");

    // a hit never reports an eviction
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) && r_o_hit |-> !r_o_ev)
        else $error("hit result carries an eviction");

endmodule

### sim/tb_second_chance_page_replacer_unit.sv
// self-checking testbench for the second-chance page replacer: directed and random page streams
`timescale 1ns / 1ps

module tb_second_chance_page_replacer_unit;
    import scp_pkg::*;

    localparam int FRAMES       = NUM_FRAMES_DEF;
    localparam int PG_W         = PAGE_BITS_DEF;
    // settle time for the final drain covers the worst miss on a full set, leave some margin
    localparam int DRAIN_CYCLES = NUM_FRAMES_DEF + 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_ITEMS  = 95;

    // one predicted result per page request
    typedef struct packed {
        logic             hit;
        logic             ev_valid;
        logic [PG_W-1:0]  ev_page;
        logic [CNT_W-1:0] hit_total;
        logic [CNT_W-1:0] miss_total;
    } t_lookup_outcome;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic [PG_W-1:0]   i_page;
    logic              o_valid;
    logic              i_stall;
    logic              o_hit;
    logic              o_evicted_valid;
    logic [PG_W-1:0]   o_evicted_page;
    logic [CNT_W-1:0]  o_hit_total;
    logic [CNT_W-1:0]  o_miss_total;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [CFG_W-1:0]  i_cfg_data;

    second_chance_page_replacer_unit #(
        .NUM_FRAMES (FRAMES),
        .PAGE_BITS  (PG_W)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_page          (i_page),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_hit           (o_hit),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_page  (o_evicted_page),
        .o_hit_total     (o_hit_total),
        .o_miss_total    (o_miss_total),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    // shadow copy of the frame set, kept in step with every accepted request
    logic [PG_W-1:0]  frame_page [FRAMES];
    bit               frame_ref  [FRAMES];
    int unsigned      fill_level;
    int unsigned      hand;
    logic [CNT_W-1:0] hit_count;
    logic [CNT_W-1:0] miss_count;
    logic [CFG_W-1:0] capacity_reg;

    t_lookup_outcome  lookup_outcomes_q [$];

    // bookkeeping
    int errors;
    int pages_sent;
    int results_checked;
    int hits_seen;
    int evictions_seen;
    int capacity_writes;
    int blocked_cycles;
    int cycles;

    // sender and receiver pacing knobs
    int tx_burst_left;
    bit tx_quiet;
    bit rx_quiet;
    int rx_hold_left;
    int rx_run_left;
    bit rx_stall_on;

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // cycle counter doubles as the watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_valid && o_stall)
            blocked_cycles <= blocked_cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: watchdog expired after %0d cycles", $time, cycles);
            $display("FAIL");
            $finish;
        end
    end

    // empty every frame, the hand goes back to frame 0
    function automatic void clear_frames();
        for (int i = 0; i < FRAMES; i++) begin
            frame_page[i] = '0;
            frame_ref[i]  = 1'b0;
        end
        fill_level = 0;
        hand       = 0;
    endfunction

    // second-chance replacement on the shadow frame set, returns what the block should report
    function automatic t_lookup_outcome replace_page(logic [PG_W-1:0] pg);
        t_lookup_outcome r;
        int unsigned     cap;
        int unsigned     h;
        int unsigned     n;
        bit              found;
        r     = '0;
        found = 1'b0;
        // out-of-range capacity is clamped to 1..FRAMES
        cap = capacity_reg;
        if (cap < 1)
            cap = 1;
        if (cap > FRAMES)
            cap = FRAMES;
        for (int i = 0; i < fill_level; i++) begin
            if (!found && frame_page[i] == pg) begin
                frame_ref[i] = 1'b1;
                found        = 1'b1;
            end
        end
        if (found) begin
            r.hit = 1'b1;
            if (hit_count != '1)
                hit_count++;
        end else begin
            if (miss_count != '1)
                miss_count++;
            if (fill_level < cap) begin
                // free frame still available
                frame_page[fill_level] = pg;
                frame_ref[fill_level]  = 1'b0;
                fill_level++;
            end else begin
                // sweep: referenced frames get their second chance
                h = (hand >= cap) ? 0 : hand;
                n = 0;
                while (frame_ref[h] && n <= cap) begin
                    frame_ref[h] = 1'b0;
                    h = (h + 1 >= cap) ? 0 : h + 1;
                    n++;
                end
                r.ev_valid    = 1'b1;
                r.ev_page     = frame_page[h];
                frame_page[h] = pg;
                frame_ref[h]  = 1'b0;
                hand          = (h + 1 >= cap) ? 0 : h + 1;
            end
        end
        r.hit_total  = hit_count;
        r.miss_total = miss_count;
        return r;
    endfunction

    // receiver: long hold-off on demand, otherwise quiet or a random on/off run pattern
    always @(posedge i_clk) begin
        if (rx_hold_left > 0) begin
            i_stall      <= 1'b1;
            rx_hold_left <= rx_hold_left - 1;
        end else if (rx_quiet) begin
            i_stall <= 1'b0;
        end else begin
            if (rx_run_left == 0) begin
                rx_stall_on = !rx_stall_on;
                rx_run_left = rx_stall_on ? $urandom_range(1, 5) : $urandom_range(1, 10);
            end
            rx_run_left--;
            i_stall <= rx_stall_on;
        end
    end

    task automatic check_field(input string name, input logic [CNT_W-1:0] want,
                               input logic [CNT_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    // result checker: every accepted result against the oldest prediction
    always @(posedge i_clk) begin
        t_lookup_outcome want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (lookup_outcomes_q.size() == 0) begin
                $display("%0t: result with no request outstanding, expected none actual %h",
                         $time, o_evicted_page);
                errors++;
            end else begin
                want = lookup_outcomes_q[0];
                lookup_outcomes_q.delete(0);
                check_field("hit", want.hit, o_hit);
                check_field("evicted_valid", want.ev_valid, o_evicted_valid);
                check_field("evicted_page", want.ev_page, o_evicted_page);
                check_field("hit_total", want.hit_total, o_hit_total);
                check_field("miss_total", want.miss_total, o_miss_total);
                results_checked++;
                if (want.hit)
                    hits_seen++;
                if (want.ev_valid)
                    evictions_seen++;
            end
        end
    end

    // one page request; valid stays high after acceptance until the next burst gap or drain
    task automatic send_page(input logic [PG_W-1:0] pg);
        int              gap;
        t_lookup_outcome pred;
        if (tx_burst_left == 0) begin
            tx_burst_left = $urandom_range(1, 16);
            gap = tx_quiet ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        tx_burst_left--;
        i_valid <= 1'b1;
        i_page  <= pg;
        do @(posedge i_clk); while (o_stall);
        pred = replace_page(pg);
        lookup_outcomes_q = {lookup_outcomes_q, pred};
        pages_sent++;
    endtask

    // stop requesting and wait until every predicted result has come back
    task automatic drain_results(input int settle);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (lookup_outcomes_q.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    // capacity write, only with the block idle; it also empties the frames
    task automatic write_capacity(input logic [CFG_W-1:0] value);
        drain_results(4);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid  <= 1'b0;
        capacity_reg = value;
        clear_frames();
        capacity_writes++;
    endtask

    // page from a working set of ws pages around base, with some far-off noise
    function automatic logic [PG_W-1:0] pick_page(logic [PG_W-1:0] base, int ws);
        if ($urandom_range(0, 9) < 8)
            return base ^ PG_W'($urandom_range(0, ws - 1));
        return PG_W'($urandom);
    endfunction

    // default capacity: fill with extreme pages, hit some, then force a sweep
    task automatic test_fill_and_hit();
        send_page(16'h0000);
        send_page(16'hFFFF);
        send_page(16'hA5A5);
        send_page(16'h5A5A);
        send_page(16'h0000);
        send_page(16'hFFFF);
        for (int p = 1; p <= 12; p++)
            send_page(PG_W'(p));
        // first two frames referenced, so the hand skips them and evicts the third
        send_page(16'h1234);
        send_page(16'h1234);
    endtask

    // capacity zero behaves as a single frame
    task automatic test_tiny_capacity();
        write_capacity(5'd0);
        send_page(16'h0007);
        send_page(16'h0007);
        // referenced single frame: sweep clears it, wraps, and evicts it anyway
        send_page(16'h0008);
        send_page(16'h0008);
    endtask

    // random phases over several capacities, including the clamped extremes
    task automatic test_random_capacities();
        logic [CFG_W-1:0] caps [10];
        logic [PG_W-1:0]  base;
        int               eff;
        caps = '{5'd1, 5'd2, 5'd31, 5'd16, 5'd17, 5'd3, 5'd0, 5'd8, 5'd5, 5'd0};
        caps[9] = CFG_W'($urandom_range(0, 31));
        for (int ph = 0; ph < 10; ph++) begin
            write_capacity(caps[ph]);
            // some phases run with no idling on one side or the other
            tx_quiet = (ph % 4 == 1);
            rx_quiet = (ph % 3 == 0);
            eff = (caps[ph] == 0) ? 1 : (caps[ph] > FRAMES) ? FRAMES : caps[ph];
            base = PG_W'($urandom);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (k % 32 == 31)
                    base = PG_W'($urandom);
                send_page(pick_page(base, eff + $urandom_range(0, 3)));
            end
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    // receiver holds off for a long stretch while requests keep coming
    task automatic test_back_pressure();
        logic [PG_W-1:0] base;
        write_capacity(5'd4);
        base         = PG_W'($urandom);
        tx_quiet     = 1'b1;
        rx_hold_left = 300;
        for (int k = 0; k < 40; k++)
            send_page(pick_page(base, 6));
        tx_quiet = 1'b0;
    endtask

    initial begin
        // every input known from time zero, reset held low
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_page        = '0;
        i_stall       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        errors          = 0;
        pages_sent      = 0;
        results_checked = 0;
        hits_seen       = 0;
        evictions_seen  = 0;
        capacity_writes = 0;
        blocked_cycles  = 0;
        cycles          = 0;
        tx_burst_left   = 0;
        tx_quiet        = 1'b0;
        rx_quiet        = 1'b0;
        rx_hold_left    = 0;
        rx_run_left     = 0;
        rx_stall_on     = 1'b0;
        clear_frames();
        hit_count    = '0;
        miss_count   = '0;
        capacity_reg = FIU_RESET;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_fill_and_hit();
        test_tiny_capacity();
        test_random_capacities();
        test_back_pressure();

        drain_results(DRAIN_CYCLES);
        if (lookup_outcomes_q.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, lookup_outcomes_q.size());
            errors++;
        end
        $display("covered %0d page requests, %0d results checked (%0d hits, %0d evictions)",
                 pages_sent, results_checked, hits_seen, evictions_seen);
        $display("%0d capacity writes, input held off by the block for %0d cycles",
                 capacity_writes, blocked_cycles);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
